// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the CSV tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define CSVT_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a consequence holds in the same cycle as its antecedent.
`define CSVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/csvt_pkg.sv
// Package with the types, constants and classifier function of the CSV tokenizer.
package csvt_pkg;

    localparam int MAX_COLUMNS_DEF    = 64;
    localparam int ROW_COUNT_BITS_DEF = 32;

    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 32;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] COMMA_BYTE  = 8'h2C;
    localparam logic [7:0] DOT_BYTE    = 8'h2E;
    localparam logic [7:0] PLUS_BYTE   = 8'h2B;
    localparam logic [7:0] MINUS_BYTE  = 8'h2D;
    localparam logic [7:0] ZERO_BYTE   = 8'h30;
    localparam logic [7:0] NINE_BYTE   = 8'h39;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_CELL    = 2'd1,
        KIND_ROW     = 2'd2,
        KIND_HEADER  = 2'd3
    } kind_t;

    // Cell classes and column types share one code space; null doubles as empty.
    typedef enum logic [1:0] {
        CLS_NULL   = 2'd0,
        CLS_INT    = 2'd1,
        CLS_DOUBLE = 2'd2,
        CLS_STRING = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        N_START    = 3'd0,
        N_SIGN     = 3'd1,
        N_ZERO     = 3'd2,
        N_INTEGER  = 3'd3,
        N_DOT      = 3'd4,
        N_FRACTION = 3'd5,
        N_REJECT   = 3'd6
    } dfa_t;

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            byte_v;
        logic [COL_OUT_W-1:0]  col;
        class_t                cls;
        class_t                ctype;
        logic [ROW_OUT_W-1:0]  row;
        logic                  ovf;
        logic                  last;
    } token_t;

    // One queue entry holds every word caused by one text item.
    typedef struct packed {
        token_t r0;
        logic   has_r1;
        token_t r1;
    } rec_t;

    function automatic dfa_t dfa_next(input dfa_t s, input logic [7:0] b);
        logic digit;
        dfa_t n;
        digit = (b >= ZERO_BYTE) && (b <= NINE_BYTE);
        case (s)
            N_START:
            begin
                if (b == PLUS_BYTE || b == MINUS_BYTE)
                    n = N_SIGN;
                else if (b == ZERO_BYTE)
                    n = N_ZERO;
                else if (digit)
                    n = N_INTEGER;
                else
                    n = N_REJECT;
            end
            N_SIGN:
                n = (b == ZERO_BYTE) ? N_ZERO : N_REJECT;
            N_ZERO:
                n = (b == DOT_BYTE) ? N_DOT : N_REJECT;
            N_INTEGER:
            begin
                if (digit)
                    n = N_INTEGER;
                else if (b == DOT_BYTE)
                    n = N_DOT;
                else
                    n = N_REJECT;
            end
            N_DOT, N_FRACTION:
                n = digit ? N_FRACTION : N_REJECT;
            default:
                n = N_REJECT;
        endcase
        return n;
    endfunction

endpackage

// File: hw/rtl/csvt_ifs.sv
// Valid/ready channel interfaces for the text input and the token output.
interface csvt_text_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_byte;

    modport source(output valid, output req_type, output char_byte, input ready);
    modport sink(input valid, input req_type, input char_byte, output ready);
endinterface

interface csvt_token_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [6:0]  column_index;
    logic [1:0]  cell_class;
    logic [1:0]  column_type;
    logic [31:0] row_number;
    logic        column_overflow;
    logic        last;

    modport source(output valid, output out_kind, output out_byte, output column_index,
                   output cell_class, output column_type, output row_number,
                   output column_overflow, output last, input ready);
    modport sink(input valid, input out_kind, input out_byte, input column_index,
                 input cell_class, input column_type, input row_number,
                 input column_overflow, input last, output ready);
endinterface

// File: hw/rtl/csv_cell_tokenizer_with_typing.sv
// Top level of the CSV cell tokenizer with per-column type inference.
//
// The text channel takes one word per cycle while ready: a text byte or an end-of-line mark.
// The first line is the header; it only counts columns, split on the delimiter
// register (cfg_we/cfg_wdata, reset value comma), and ends with a header-done word.
// Every later line is split on comma under the quote rules and yields content
// bytes, cell-closed words carrying the inferred class and the column type, and
// a row-closed word at the end of the line. Each text word yields zero, one or
// two token words; the last of them has last set.
// Throughput is one text word per cycle while ready is high; the token channel
// sets the pace, since a text word that yields two token words needs a token
// handshake for each of them.
// The column types live in a memory with a registered read: the read is issued
// when a cell closes and the merged type is written back in the next cycle,
// with forwarding for back-to-back closes of the same column.
// Reset clears the control state and the per-column valid bits, so every
// column reads as empty. The header clears the valid bits again.
// When the receiver stalls, token words collect in a four-entry queue and the
// text channel drops ready before that queue could overflow; nothing is lost.
`include "assert_macros.svh"

module csv_cell_tokenizer_with_typing #(
    parameter int MAX_COLUMNS    = csvt_pkg::MAX_COLUMNS_DEF,
    parameter int ROW_COUNT_BITS = csvt_pkg::ROW_COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    csvt_text_if.sink         text,
    csvt_token_if.source      token,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata
);
    import csvt_pkg::*;

    localparam int COL_W      = $clog2(MAX_COLUMNS + 1);
    localparam int ADDR_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [COL_W-1:0]          COL_MAX = COL_W'(MAX_COLUMNS);
    localparam logic [ROW_COUNT_BITS-1:0] ROW_MAX = '1;

    // Parser state.
    logic [7:0]                delim_reg;
    logic                      header_seen_reg, header_seen_next;
    logic [COL_W-1:0]          col_count_reg, col_count_next;
    logic [COL_W-1:0]          cur_col_reg, cur_col_next;
    logic                      in_quote_reg, in_quote_next;
    logic                      quote_pend_reg, quote_pend_next;
    logic                      bss_reg, bss_next;
    logic                      nonempty_reg, nonempty_next;
    dfa_t                      dfa_reg, dfa_next_s;
    logic [ROW_COUNT_BITS-1:0] rows_reg, rows_next;

    logic       accept;
    logic       eol;
    logic [7:0] in_byte;
    logic       do_close, do_content, do_row, do_header;
    logic [COL_W-1:0] col_inc;

    // Stage B: the item whose column-type read data is present this cycle.
    logic                  sb_valid_reg;
    logic                  sb_close_reg, sb_close_next;
    logic                  sb_main_reg, sb_main_next;
    kind_t                 sb_kind_reg, sb_kind_next;
    logic [7:0]            sb_byte_reg;
    logic [COL_W-1:0]      sb_col_reg;
    logic                  sb_ovf_reg, sb_ovf_next;
    logic                  sb_int_reg, sb_int_next;
    logic                  sb_dbl_reg, sb_dbl_next;
    logic                  sb_nonempty_reg;
    logic [ROW_OUT_W-1:0]  sb_row_before_reg, sb_row_after_reg;
    logic [COL_W-1:0]      sb_main_col_reg, sb_main_col_next;
    logic                  sb_main_ovf_reg, sb_main_ovf_next;

    // Column-type memory with valid bits and a forwarding path.
    class_t                col_type_mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] type_valid_reg;
    class_t                rdata_reg;
    logic                  rvalid_reg;
    logic                  fwd_hit_reg;
    class_t                fwd_data_reg;
    logic [ADDR_W-1:0]     rd_addr, wr_addr;
    logic                  mem_we;
    class_t                wr_data;

    class_t ctype_raw, ctype_old, ctype_new, cls;
    token_t close_tok, main_tok;
    rec_t   push_rec;

    // Output queue.
    rec_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             phase_reg;
    rec_t             head;
    token_t           out_tok;
    logic             out_hs, pop, push;

    assign eol     = text.req_type;
    assign in_byte = text.char_byte;
    assign accept  = text.valid && text.ready;
    assign col_inc = (cur_col_reg < COL_MAX) ? cur_col_reg + COL_W'(1) : cur_col_reg;

    // Room is kept for the item now in stage B and for the one being accepted.
    assign text.ready = (count_reg + CNT_W'(sb_valid_reg)) <= CNT_W'(FIFO_DEPTH - 1);

    always_comb
    begin
        header_seen_next = header_seen_reg;
        col_count_next   = col_count_reg;
        cur_col_next     = cur_col_reg;
        in_quote_next    = in_quote_reg;
        quote_pend_next  = quote_pend_reg;
        bss_next         = bss_reg;
        nonempty_next    = nonempty_reg;
        dfa_next_s       = dfa_reg;
        rows_next        = rows_reg;
        do_close         = 1'b0;
        do_content       = 1'b0;
        do_row           = 1'b0;
        do_header        = 1'b0;
        if (accept)
        begin
            if (!header_seen_reg)
            begin
                if (!eol)
                begin
                    if (in_byte == delim_reg)
                    begin
                        if (col_count_reg < COL_MAX)
                            col_count_next = col_count_reg + COL_W'(1);
                        bss_next = 1'b0;
                    end
                    else
                    begin
                        bss_next = 1'b1;
                    end
                end
                else
                begin
                    // A trailing empty header piece is not counted.
                    if (bss_reg && col_count_reg < COL_MAX)
                        col_count_next = col_count_reg + COL_W'(1);
                    header_seen_next = 1'b1;
                    do_header        = 1'b1;
                end
            end
            else if (eol)
            begin
                // A quote still pending at the line end is dropped.
                do_close = bss_reg;
                do_row   = 1'b1;
                if (rows_reg != ROW_MAX)
                    rows_next = rows_reg + ROW_COUNT_BITS'(1);
            end
            else if (quote_pend_reg)
            begin
                quote_pend_next = 1'b0;
                if (in_byte == COMMA_BYTE)
                    do_close = 1'b1;
                else
                    do_content = 1'b1;
            end
            else
            begin
                bss_next = 1'b1;
                if (in_byte == QUOTE_BYTE)
                begin
                    in_quote_next   = 1'b1;
                    quote_pend_next = 1'b1;
                end
                else if (in_byte == COMMA_BYTE && !in_quote_reg)
                    do_close = 1'b1;
                else
                    do_content = 1'b1;
            end

            if (do_content)
            begin
                dfa_next_s    = dfa_next(dfa_reg, in_byte);
                nonempty_next = 1'b1;
            end
            if (do_close)
                cur_col_next = col_inc;
            if (do_close || do_row || do_header)
            begin
                dfa_next_s      = N_START;
                nonempty_next   = 1'b0;
                in_quote_next   = 1'b0;
                quote_pend_next = 1'b0;
                bss_next        = 1'b0;
            end
            if (do_row || do_header)
                cur_col_next = '0;
        end
    end

    // Stage B contents for the accepted item.
    always_comb
    begin
        sb_close_next    = do_close;
        sb_main_next     = do_content || do_row || do_header;
        sb_ovf_next      = cur_col_reg >= col_count_reg;
        sb_int_next      = (dfa_reg == N_ZERO) || (dfa_reg == N_INTEGER);
        sb_dbl_next      = sb_int_next || (dfa_reg == N_FRACTION);
        sb_kind_next     = KIND_CONTENT;
        sb_main_col_next = cur_col_reg;
        sb_main_ovf_next = 1'b0;
        if (do_header)
        begin
            sb_kind_next     = KIND_HEADER;
            sb_main_col_next = col_count_next;
        end
        else if (do_row)
        begin
            sb_kind_next     = KIND_ROW;
            sb_main_col_next = do_close ? col_inc : cur_col_reg;
        end
        else
        begin
            sb_main_ovf_next = sb_ovf_next;
        end
    end

    assign rd_addr = cur_col_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg       <= DELIM_RESET;
            header_seen_reg <= 1'b0;
            col_count_reg   <= '0;
            cur_col_reg     <= '0;
            in_quote_reg    <= 1'b0;
            quote_pend_reg  <= 1'b0;
            bss_reg         <= 1'b0;
            nonempty_reg    <= 1'b0;
            dfa_reg         <= N_START;
            rows_reg        <= '0;
            sb_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                delim_reg <= cfg_wdata;
            header_seen_reg <= header_seen_next;
            col_count_reg   <= col_count_next;
            cur_col_reg     <= cur_col_next;
            in_quote_reg    <= in_quote_next;
            quote_pend_reg  <= quote_pend_next;
            bss_reg         <= bss_next;
            nonempty_reg    <= nonempty_next;
            dfa_reg         <= dfa_next_s;
            rows_reg        <= rows_next;
            sb_valid_reg    <= sb_close_next || sb_main_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sb_close_reg      <= sb_close_next;
        sb_main_reg       <= sb_main_next;
        sb_kind_reg       <= sb_kind_next;
        sb_byte_reg       <= in_byte;
        sb_col_reg        <= cur_col_reg;
        sb_ovf_reg        <= sb_ovf_next;
        sb_int_reg        <= sb_int_next;
        sb_dbl_reg        <= sb_dbl_next;
        sb_nonempty_reg   <= nonempty_reg;
        sb_row_before_reg <= ROW_OUT_W'(rows_reg);
        sb_row_after_reg  <= ROW_OUT_W'(rows_next);
        sb_main_col_reg   <= sb_main_col_next;
        sb_main_ovf_reg   <= sb_main_ovf_next;
        // A write in the same cycle as a read of the same column is forwarded.
        fwd_hit_reg       <= mem_we && (wr_addr == rd_addr);
        fwd_data_reg      <= wr_data;
    end

    // Column-type memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            col_type_mem[wr_addr] <= wr_data;
        rdata_reg <= col_type_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_valid_reg <= '0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            if (do_header)
                type_valid_reg <= '0;
            else if (mem_we)
                type_valid_reg[wr_addr] <= 1'b1;
            rvalid_reg <= type_valid_reg[rd_addr];
        end
    end

    // Classification and type merge in stage B.
    always_comb
    begin
        if (fwd_hit_reg)
            ctype_raw = fwd_data_reg;
        else if (rvalid_reg)
            ctype_raw = rdata_reg;
        else
            ctype_raw = CLS_NULL;
        ctype_old = sb_ovf_reg ? CLS_NULL : ctype_raw;

        if (sb_int_reg && ctype_old <= CLS_INT)
            cls = CLS_INT;
        else if (sb_dbl_reg && ctype_old <= CLS_DOUBLE)
            cls = CLS_DOUBLE;
        else if (sb_nonempty_reg)
            cls = CLS_STRING;
        else
            cls = CLS_NULL;

        ctype_new = (cls > ctype_old) ? cls : ctype_old;
    end

    assign mem_we  = sb_valid_reg && sb_close_reg && !sb_ovf_reg;
    assign wr_addr = sb_col_reg[ADDR_W-1:0];
    assign wr_data = ctype_new;

    always_comb
    begin
        close_tok.kind   = KIND_CELL;
        close_tok.byte_v = 8'h00;
        close_tok.col    = COL_OUT_W'(sb_col_reg);
        close_tok.cls    = cls;
        close_tok.ctype  = sb_ovf_reg ? CLS_NULL : ctype_new;
        close_tok.row    = sb_row_before_reg;
        close_tok.ovf    = sb_ovf_reg;
        close_tok.last   = !sb_main_reg;

        main_tok.kind    = sb_kind_reg;
        main_tok.byte_v  = (sb_kind_reg == KIND_CONTENT) ? sb_byte_reg : 8'h00;
        main_tok.col     = COL_OUT_W'(sb_main_col_reg);
        main_tok.cls     = CLS_NULL;
        main_tok.ctype   = CLS_NULL;
        main_tok.row     = (sb_kind_reg == KIND_ROW) ? sb_row_after_reg : sb_row_before_reg;
        main_tok.ovf     = sb_main_ovf_reg;
        main_tok.last    = 1'b1;

        push_rec.r0      = sb_close_reg ? close_tok : main_tok;
        push_rec.has_r1  = sb_close_reg && sb_main_reg;
        push_rec.r1      = main_tok;
    end

    // Output queue and serializer for items that yield two words.
    assign push    = sb_valid_reg;
    assign head    = fifo_mem[rd_ptr_reg];
    assign out_tok = phase_reg ? head.r1 : head.r0;
    assign out_hs  = token.valid && token.ready;
    assign pop     = out_hs && (phase_reg || !head.has_r1);

    assign token.valid           = count_reg != '0;
    assign token.out_kind        = out_tok.kind;
    assign token.out_byte        = out_tok.byte_v;
    assign token.column_index    = out_tok.col;
    assign token.cell_class      = out_tok.cls;
    assign token.column_type     = out_tok.ctype;
    assign token.row_number      = out_tok.row;
    assign token.column_overflow = out_tok.ovf;
    assign token.last            = out_tok.last;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
            if (pop)
                phase_reg <= 1'b0;
            else if (out_hs)
                phase_reg <= 1'b1;
        end
    end

    `CSVT_ASSERT(a_fifo_bound, clk, rst_n, count_reg <= CNT_W'(FIFO_DEPTH), "output queue overfilled")
    `CSVT_ASSERT_IMP(a_push_room, clk, rst_n, sb_valid_reg, count_reg < CNT_W'(FIFO_DEPTH), "stage B pushes into a full queue")
    `CSVT_ASSERT_IMP(a_phase_head, clk, rst_n, phase_reg, (count_reg != '0) && head.has_r1, "second word selected without a two-word entry")
    `CSVT_ASSERT(a_col_bound, clk, rst_n, (cur_col_reg <= COL_MAX) && (col_count_reg <= COL_MAX), "column counter beyond limit")
    `CSVT_ASSERT_IMP(a_close_after_header, clk, rst_n, sb_valid_reg && sb_close_reg, header_seen_reg, "cell closed before the header finished")

endmodule
